FILE: sv/sfd_pkg.sv
// Package for the serial frame deframer: payload types, descriptor type, constants.
`default_nettype none
package sfd_pkg;

   // Payload store geometry: two banks of sixteen bytes (fifteen used per frame)
   localparam int StoreDepth  = 15;
   localparam int BankBits    = 1;
   localparam int PosBits     = 4;
   localparam int RamAddrW    = BankBits + PosBits;
   localparam int RamDepth    = 1 << RamAddrW;

   // Descriptor queue between the parser and the emitter
   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   // Configuration port
   localparam int CsrAddrW    = 3;
   localparam int CsrDataW    = 32;
   localparam logic [CsrAddrW-1:0] RegStartByte = 3'd0;
   localparam logic [7:0] StartByteReset = 8'h02;

   // Header nibble masks
   localparam logic [7:0] IdMask  = 8'hf0;
   localparam logic [7:0] LenMask = 8'h0f;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       parity_error;
      logic       framing_error;
   } req_type;

   typedef struct packed {
      logic [3:0] msg_id;
      logic [3:0] msg_len;
      logic [3:0] byte_pos;
      logic [7:0] payload_byte;
      logic       has_payload;
      logic       last;
   } rsp_type;

   // One checked frame waiting to be emitted
   typedef struct packed {
      logic [3:0]          id;
      logic [3:0]          len;
      logic [BankBits-1:0] bank;
   } desc_type;

endpackage
`default_nettype wire

FILE: sv/sfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sfd_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/sfd_front.sv
// Frame parser: filters bad bytes, tracks header, payload and checksum, queues good frames.
`default_nettype none
module sfd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [7:0]                    start_byte,
   input  wire logic                          req_valid,
   input  wire sfd_pkg::req_type              req_data,
   output logic                               req_ready,
   input  wire logic                          q_full,
   output logic                               push,
   output sfd_pkg::desc_type                  push_desc,
   output logic                               ram_wr_en,
   output logic [sfd_pkg::RamAddrW-1:0]       ram_wr_addr,
   output logic [7:0]                         ram_wr_data
);

   localparam logic [1:0] PhWait = 2'd0;
   localparam logic [1:0] PhHead = 2'd1;
   localparam logic [1:0] PhData = 2'd2;
   localparam logic [1:0] PhSum  = 2'd3;

   logic [1:0]                     phase_ff, phase_in;
   logic [7:0]                     sum_ff, sum_in;
   logic [3:0]                     id_ff, id_in;
   logic [3:0]                     len_ff, len_in;
   logic [3:0]                     seen_ff, seen_in;
   logic [sfd_pkg::BankBits-1:0]   bank_ff, bank_in;
   logic                           take;
   logic [7:0]                     ch;
   logic [3:0]                     seen_inc;

   // both queued banks busy: hold the line until the emitter frees one
   assign req_ready = !q_full;
   assign ch        = req_data.rx_byte;
   assign take      = req_valid && req_ready &&
                      !req_data.parity_error && !req_data.framing_error;
   assign seen_inc  = seen_ff + 4'd1;

   // parser next state
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      bank_in  = bank_ff;
      push     = 1'b0;
      if (take) begin
         unique case (phase_ff)
            PhWait: begin
               if (ch == start_byte) begin
                  phase_in = PhHead;
               end
            end
            PhHead: begin
               id_in    = 4'((ch & sfd_pkg::IdMask) >> 4);
               len_in   = 4'(ch & sfd_pkg::LenMask);
               seen_in  = 4'd0;
               sum_in   = ch;
               phase_in = ((ch & sfd_pkg::LenMask) != 8'd0) ? PhData : PhSum;
            end
            PhData: begin
               sum_in  = sum_ff + ch;
               seen_in = seen_inc;
               if (seen_inc == len_ff) begin
                  phase_in = PhSum;
               end
            end
            default: begin
               if (ch == sum_ff) begin
                  push    = 1'b1;
                  bank_in = bank_ff + 1'b1;
               end
               phase_in = PhWait;
            end
         endcase
      end
   end

   assign push_desc.id   = id_ff;
   assign push_desc.len  = len_ff;
   assign push_desc.bank = bank_ff;

   // payload bytes land in the bank of the frame in progress
   assign ram_wr_en   = take && (phase_ff == PhData);
   assign ram_wr_addr = {bank_ff, seen_ff};
   assign ram_wr_data = ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhWait;
         sum_ff   <= 8'd0;
         id_ff    <= 4'd0;
         len_ff   <= 4'd0;
         seen_ff  <= 4'd0;
         bank_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         bank_ff  <= bank_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/sfd_queue.sv
// Short FIFO of checked-frame descriptors between parser and emitter.
`default_nettype none
module sfd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sfd_pkg::desc_type push_desc,
   input  wire logic              pop,
   output logic                   head_valid,
   output sfd_pkg::desc_type      head_desc,
   output logic                   full
);

   localparam logic [sfd_pkg::QueuePtrW-1:0] LastPtr =
      sfd_pkg::QueuePtrW'(sfd_pkg::QueueDepth - 1);
   localparam logic [sfd_pkg::QueueCntW-1:0] FullCnt =
      sfd_pkg::QueueCntW'(sfd_pkg::QueueDepth);

   sfd_pkg::desc_type                entry_ff [sfd_pkg::QueueDepth];
   logic [sfd_pkg::QueuePtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [sfd_pkg::QueueCntW-1:0]    count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == FullCnt);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   // overflow / underflow would corrupt the bank pairing
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("descriptor pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("descriptor popped from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: sv/sfd_back.sv
// Frame emitter: walks a queued frame's payload and presents one result per byte.
`default_nettype none
module sfd_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        head_valid,
   input  wire sfd_pkg::desc_type           head_desc,
   output logic                             pop,
   output logic                             ram_rd_en,
   output logic [sfd_pkg::RamAddrW-1:0]     ram_rd_addr,
   input  wire logic [7:0]                  ram_rd_data,
   output logic                             rsp_valid,
   output sfd_pkg::rsp_type                 rsp_data,
   input  wire logic                        rsp_ready
);

   logic [3:0]        pos_ff;
   logic              s1_valid_ff;
   sfd_pkg::rsp_type  s1_ff, s1_in;
   logic              rsp_valid_ff;
   sfd_pkg::rsp_type  rsp_ff, rsp_in;
   logic              s1_move, issue, is_last;
   logic [3:0]        pos_inc;

   // read stage advances when the output slot is free or being taken
   assign s1_move = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue   = head_valid && (!s1_valid_ff || s1_move);
   assign pos_inc = pos_ff + 4'd1;
   assign is_last = (head_desc.len == 4'd0) || (pos_inc == head_desc.len);
   assign pop     = issue && is_last;

   assign ram_rd_en   = issue;
   assign ram_rd_addr = {head_desc.bank, pos_ff};

   // result fields known at issue; payload joins from the RAM's registered read data at the output slot
   always_comb begin
      s1_in.msg_id       = head_desc.id;
      s1_in.msg_len      = head_desc.len;
      s1_in.byte_pos     = pos_ff;
      s1_in.payload_byte = 8'd0;
      s1_in.has_payload  = (head_desc.len != 4'd0);
      s1_in.last         = is_last;
   end

   // output slot: staged fields plus the RAM byte
   always_comb begin
      rsp_in              = s1_ff;
      rsp_in.payload_byte = s1_ff.has_payload ? ram_rd_data : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 4'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            pos_ff <= is_last ? 4'd0 : pos_inc;
         end
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // position must restart at zero for every new frame
   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> (pos_ff == 4'd0))
      else $error("byte position not reset after last byte");
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.has_payload) |->
         (rsp_data.last && rsp_data.payload_byte == 8'd0))
      else $error("empty message result malformed");
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.has_payload) |-> (rsp_data.byte_pos < rsp_data.msg_len))
      else $error("byte position beyond message length");

endmodule
`default_nettype wire

FILE: sv/serial_frame_deframer.sv
// Serial frame deframer top level: CSR port, parser, descriptor queue, payload RAM, emitter.
//
// Usage:
//   req_* carries one received UART byte per transfer with its parity and
//   framing error flags. Flagged bytes are discarded. The parser looks for
//   the start byte (CSR register 0, reset 0x02), then a header (id in the
//   high nibble, length in the low nibble), the payload and the checksum.
//   rsp_* carries one result per payload byte of every frame whose checksum
//   matches, or one empty result for a zero-length frame; last marks the
//   final result. Bad frames vanish silently.
//   Input takes one byte per cycle while the queue has room. A frame's
//   first result passes the descriptor queue, read stage and output slot,
//   then one result per cycle while rsp_ready is high, set by the RAM's single read port.
//   Up to two checked frames wait for the emitter, each in its own RAM bank;
//   while both wait, req_ready is low. A stalled receiver holds the current
//   result and back-pressures into the queue.
//   Reset returns the parser to the start search, empties the queue and
//   restores the start byte to 0x02. The payload RAM needs no clearing.
//   csr_*: APB-style, pready always high, one register at byte address 0.
`default_nettype none
module serial_frame_deframer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire sfd_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output sfd_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [sfd_pkg::CsrAddrW-1:0]    csr_paddr,
   input  wire logic [sfd_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic [sfd_pkg::CsrDataW-1:0]         csr_prdata,
   output logic                                 csr_pready
);

   logic [7:0]                     start_byte_ff;
   logic                           csr_hit;
   logic                           q_full, q_push, q_pop, q_head_valid;
   sfd_pkg::desc_type              q_push_desc, q_head_desc;
   logic                           ram_wr_en, ram_rd_en;
   logic [sfd_pkg::RamAddrW-1:0]   ram_wr_addr, ram_rd_addr;
   logic [7:0]                     ram_wr_data, ram_rd_data;

   // register decode: word address selects the register
   assign csr_hit    = (csr_paddr[sfd_pkg::CsrAddrW-1:2] ==
                        sfd_pkg::RegStartByte[sfd_pkg::CsrAddrW-1:2]);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {{(sfd_pkg::CsrDataW-8){1'b0}}, start_byte_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= sfd_pkg::StartByteReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         start_byte_ff <= csr_pwdata[7:0];
      end
   end

   sfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start_byte  (start_byte_ff),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_ready   (req_ready),
      .q_full      (q_full),
      .push        (q_push),
      .push_desc   (q_push_desc),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   sfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_push_desc),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_desc  (q_head_desc),
      .full       (q_full)
   );

   sfd_ram #(
      .Width (8),
      .Depth (sfd_pkg::RamDepth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_desc   (q_head_desc),
      .pop         (q_pop),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_ready   (rsp_ready)
   );

endmodule
`default_nettype wire
